[rtl/fdr_pkg.sv]
`default_nettype none

package fdr_pkg;

  localparam int SAMPLE_W = 16;
  localparam int BLK_W    = 4;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [BLK_W-1:0]           blocks_t;

  typedef struct packed {
    sample_t mix;
    sample_t fb;
  } mix_res_t;

endpackage

`default_nettype wire

[rtl/fdr_stream_if.sv]
`default_nettype none

interface fdr_in_if;
  logic            valid;
  logic            ready;
  fdr_pkg::sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface fdr_out_if;
  logic            valid;
  logic            ready;
  fdr_pkg::sample_t sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

[rtl/feedback_delay_reverb.sv]
`default_nettype none
// Pipeline: an accepted transaction is registered in stage s1, then in the out_ch register.
// Throughput: one transaction per cycle when out_ch is ready; the ring read for an item and
//   the write-back of the previous item use separate memory ports, with forwarding when
//   they hit one entry. Reset: synchronous, active low; delay returns to 0 and the write
//   pointer to 0, then a clear pass zeroes the ring while in_ch.ready stays low.

module feedback_delay_reverb #(
  parameter int BLOCK_SAMPLES = 4800,
  parameter int MAX_BLOCKS    = 10,
  parameter int RING_DEPTH    = 48000
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  fdr_in_if.sink                   in_ch,
  fdr_out_if.source                out_ch,
  input  wire logic                cfg_we,
  input  wire fdr_pkg::blocks_t    cfg_wdata
);

  localparam int AW     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int NTAB   = 2 ** fdr_pkg::BLK_W;

  logic [AW-1:0] dly_tab [NTAB];

  for (genvar b = 0; b < NTAB; b++) begin : g_dly
    assign dly_tab[b] = AW'((b * BLOCK_SAMPLES) % RING_DEPTH);
  end

  fdr_pkg::blocks_t  blk_r;
  logic [AW-1:0]     wp_r;
  logic              clr_busy_r;
  logic [AW-1:0]     clr_cnt_r;

  logic              s1_v_r;
  logic              s1_byp_r;
  logic [AW-1:0]     s1_wp_r;
  fdr_pkg::sample_t  s1_smp_r;
  logic              fwd_r;
  fdr_pkg::sample_t  fwd_d_r;

  logic              out_v_r;
  fdr_pkg::sample_t  out_d_r;

  logic              byp;
  logic [AW-1:0]     rd_lag;
  logic [AW:0]       rd_wide;
  logic [AW-1:0]     rd_addr;
  logic              in_acc;
  logic              s1_go;
  logic              s1_wr;
  logic              fwd_nxt;
  fdr_pkg::sample_t  entry;
  fdr_pkg::sample_t  rdata;
  fdr_pkg::mix_res_t res;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  fdr_pkg::sample_t  ram_wdata;

  assign byp    = (blk_r == '0);
  assign rd_lag = dly_tab[blk_r];
  assign s1_go  = s1_v_r && (!out_v_r || out_ch.ready);
  assign s1_wr  = s1_go && !s1_byp_r;

  assign in_ch.ready = !clr_busy_r && (!s1_v_r || s1_go);
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    if (wp_r >= rd_lag) begin
      rd_wide = {1'b0, wp_r} - {1'b0, rd_lag};
    end else begin
      rd_wide = {1'b0, wp_r} + (AW+1)'(RING_DEPTH) - {1'b0, rd_lag};
    end
    rd_addr = rd_wide[AW-1:0];
    fwd_nxt = s1_wr && (rd_addr == s1_wp_r);
  end

  assign entry = fwd_r ? fwd_d_r : rdata;

  fdr_mix u_mix (
    .smp   (s1_smp_r),
    .entry (entry),
    .res   (res)
  );

  always_comb begin
    if (clr_busy_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_wr;
      ram_waddr = s1_wp_r;
      ram_wdata = res.fb;
    end
  end

  fdr_ram #(
    .W (fdr_pkg::SAMPLE_W),
    .D (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_r      <= '0;
      wp_r       <= '0;
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
      s1_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        blk_r <= (int'(cfg_wdata) > MAX_BLOCKS) ? fdr_pkg::BLK_W'(MAX_BLOCKS) : cfg_wdata;
      end
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(RING_DEPTH - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (in_acc && !byp) begin
        wp_r <= (wp_r == AW'(RING_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
      if (s1_go) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byp_r <= byp;
      s1_wp_r  <= wp_r;
      s1_smp_r <= in_ch.sample_in;
      fwd_r    <= fwd_nxt;
      fwd_d_r  <= res.fb;
    end
    if (s1_go) begin
      out_d_r <= s1_byp_r ? s1_smp_r : res.mix;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.sample_out = out_d_r;

`ifndef NO_ASSERTIONS
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_ch.ready)
    else $error("input accepted during ring clear");

  a_wp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= AW'(RING_DEPTH - 1))
    else $error("write pointer out of range");

  a_wp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_acc && !byp) |=> $stable(wp_r))
    else $error("write pointer moved without a delayed transaction");

  a_bypass_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_byp_r |=> out_ch.sample_out == $past(s1_smp_r))
    else $error("bypass transaction altered");

  a_no_write_on_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_busy_r && s1_v_r && s1_byp_r |-> !ram_we)
    else $error("ring written by bypass transaction");
`endif

endmodule

`default_nettype wire

[rtl/fdr_ram.sv]
`default_nettype none

module fdr_ram #(
  parameter  int W  = 16,
  parameter  int D  = 1024,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/fdr_mix.sv]
`default_nettype none

module fdr_mix (
  input  wire fdr_pkg::sample_t smp,
  input  wire fdr_pkg::sample_t entry,
  output fdr_pkg::mix_res_t     res
);

  logic signed [fdr_pkg::SAMPLE_W+1:0] sum;

  // 3*x + entry, then floor divide by 4; the result always fits 16 bits
  always_comb begin
    sum = {smp[fdr_pkg::SAMPLE_W-1], smp[fdr_pkg::SAMPLE_W-1], smp}
        + {smp[fdr_pkg::SAMPLE_W-1], smp, 1'b0}
        + {entry[fdr_pkg::SAMPLE_W-1], entry[fdr_pkg::SAMPLE_W-1], entry};
    res.mix = sum[fdr_pkg::SAMPLE_W+1:2];
    res.fb  = {res.mix[fdr_pkg::SAMPLE_W-1], res.mix[fdr_pkg::SAMPLE_W-1:1]};
  end

endmodule

`default_nettype wire
